// ===== hdl/rhcb_pkg.sv =====
// shared types and constants for the rolling hash chunk boundary finder
package rhcb_pkg;

  localparam int unsigned DEF_WINDOW_DEPTH = 64;
  localparam longint unsigned DEF_MAX_BUFFER = 1048576;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned MASK_CFG_W = 6;
  localparam int unsigned OFFSET_W   = 21;
  localparam int unsigned MASK_RESET = 13;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0] sum_t;

  // control that every window cell sees
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

endpackage

// ===== hdl/rolling_hash_chunk_boundary_core.sv =====
// top level of the rolling hash chunk boundary finder
// usage:
//   bytes of a buffer stream in on s_axis, one byte per word, with
//   s_axis_tlast on the final byte of the buffer. the block keeps a
//   window of the last WINDOW_DEPTH bytes in a chain of byte cells and
//   a 32-bit rotate-xor rolling sum. when the low mask_bits bits of the
//   sum are all ones, one result word goes out on m_axis with the
//   boundary offset (bytes up to and including that byte) in tdata and
//   tuser set. the rest of that buffer is swallowed. if the buffer ends
//   with no boundary, a word with offset 0 and tuser clear goes out.
//   after the last byte all hashing state returns to zero. cfg_we / cfg_wdata
//   load mask_bits (reset 13); users write while the block idles (not enforced).
// timing:
//   one byte per clock while m_axis_tready holds; a result appears on m_axis
//   the cycle after the byte that causes it. up to a boundary the sum update
//   is one rotate-xor per byte and each window cell shifts once per byte.
// stall and reset:
//   a single output register sits between the sides; input is taken
//   while that register is empty or being drained in the same cycle.
//   rst (synchronous) clears the window, sum, position and output valid.
module rolling_hash_chunk_boundary_core
  import rhcb_pkg::*;
#(
  parameter int unsigned     WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter longint unsigned MAX_BUFFER   = DEF_MAX_BUFFER
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // last_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [20:0] boundary_offset, rest zero
  output logic                  m_axis_tuser,   // found
  input  logic                  cfg_we,
  input  logic [MASK_CFG_W-1:0] cfg_wdata       // mask_bits
);

  // position counter just wide enough to hold MAX_BUFFER
  localparam int unsigned POS_W = $clog2(MAX_BUFFER + 1);
  localparam int unsigned OFS_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER);

  logic [MASK_CFG_W-1:0] mask_bits;
  sum_t                  rolling_sum;
  sum_t                  rolling_sum_next;
  logic [POS_W-1:0]      byte_position;
  logic                  boundary_seen;

  logic                  accept;
  logic                  active;
  win_ctrl_t             win_ctrl;
  byte_t                 byte_leaving;
  sum_t                  low_mask;
  logic                  hit;
  logic [POS_W-1:0]      ofs;
  logic [OFS_W-1:0]      ofs_wide;
  logic                  emit;

  logic [OFFSET_W-1:0]   out_offset;
  logic                  out_found;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_bits <= MASK_CFG_W'(MASK_RESET);
    end else if (cfg_we) begin
      mask_bits <= cfg_wdata;
    end
  end

  // input side handshake: output register free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign active        = accept && !boundary_seen;

  assign win_ctrl.shift = active;
  assign win_ctrl.clear = accept && s_axis_tlast;

  rhcb_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (win_ctrl),
    .byte_in      (s_axis_tdata),
    .byte_leaving (byte_leaving)
  );

  // rotate left by one, fold in the leaving and the entering byte
  assign rolling_sum_next = {rolling_sum[SUM_W-2:0], rolling_sum[SUM_W-1]}
                          ^ SUM_W'(byte_leaving) ^ SUM_W'(s_axis_tdata);

  // mask of 32 or more bits covers the whole sum
  always_comb begin
    if (mask_bits >= MASK_CFG_W'(SUM_W)) begin
      low_mask = '1;
    end else begin
      low_mask = (SUM_W'(1) << mask_bits[4:0]) - SUM_W'(1);
    end
  end

  assign hit = (rolling_sum_next & low_mask) == low_mask;

  // offset is position + 1, capped at the buffer bound
  assign ofs      = (byte_position == POS_MAX) ? POS_MAX : byte_position + POS_W'(1);
  assign ofs_wide = OFS_W'(ofs);

  assign emit = active && (hit || s_axis_tlast);

  // hashing state
  always_ff @(posedge clk) begin
    if (rst || (accept && s_axis_tlast)) begin
      rolling_sum   <= '0;
      byte_position <= '0;
      boundary_seen <= 1'b0;
    end else if (active) begin
      rolling_sum <= rolling_sum_next;
      if (byte_position != POS_MAX) begin
        byte_position <= byte_position + POS_W'(1);
      end
      if (hit) begin
        boundary_seen <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_offset <= hit ? ofs_wide[OFFSET_W-1:0] : '0;
      out_found  <= hit;
    end
  end

  assign m_axis_tdata = {3'b000, out_offset};
  assign m_axis_tuser = out_found;

endmodule

// ===== hdl/rhcb_cell.sv =====
// one byte cell of the sliding window
module rhcb_cell
  import rhcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  win_ctrl_t ctrl,
  input  byte_t     byte_in,
  output byte_t     byte_out
);

  byte_t held;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

endmodule

// ===== hdl/rhcb_window.sv =====
// chain of byte cells holding the last WINDOW_DEPTH bytes
module rhcb_window
  import rhcb_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  win_ctrl_t ctrl,
  input  byte_t     byte_in,
  output byte_t     byte_leaving
);

  byte_t link [WINDOW_DEPTH+1];

  assign link[0] = byte_in;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    rhcb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .byte_in  (link[i]),
      .byte_out (link[i+1])
    );
  end

  // oldest byte, the one that drops out on the next shift
  assign byte_leaving = link[WINDOW_DEPTH];

endmodule
